// ===== sv/tesp_pkg.sv =====
`default_nettype none

package tesp_pkg;

    // Byte codes seen by the parser
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_BEL   = 8'h07;
    localparam logic [7:0] BYTE_ST    = 8'h9C;
    localparam logic [7:0] BYTE_C1CSI = 8'h9B;
    localparam logic [7:0] BYTE_C1OSC = 8'h9D;
    localparam logic [7:0] BYTE_C1DCS = 8'h90;
    localparam logic [7:0] BYTE_C1SOS = 8'h98;
    localparam logic [7:0] BYTE_C1PM  = 8'h9E;
    localparam logic [7:0] BYTE_C1APC = 8'h9F;
    localparam logic [7:0] CH_DCS     = 8'h50; // 'P'
    localparam logic [7:0] CH_SOS     = 8'h58; // 'X'
    localparam logic [7:0] CH_CSI     = 8'h5B; // '['
    localparam logic [7:0] CH_OSC     = 8'h5D; // ']'
    localparam logic [7:0] CH_PM      = 8'h5E; // '^'
    localparam logic [7:0] CH_APC     = 8'h5F; // '_'
    localparam logic [7:0] CH_SAVE    = 8'h37; // '7'
    localparam logic [7:0] CH_RESTORE = 8'h38; // '8'
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SGR     = 8'h6D; // 'm'
    localparam logic [7:0] CH_CUU     = 8'h41;
    localparam logic [7:0] CH_CUD     = 8'h42;
    localparam logic [7:0] CH_CUF     = 8'h43;
    localparam logic [7:0] CH_CUB     = 8'h44;
    localparam logic [7:0] LOW7_MASK  = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CSI_TOP    = 8'h40;

    // Result kinds
    localparam logic [2:0] KIND_CHAR   = 3'd0;
    localparam logic [2:0] KIND_FUNC   = 3'd1;
    localparam logic [2:0] KIND_PARAM  = 3'd2;
    localparam logic [2:0] KIND_STRING = 3'd3;
    localparam logic [2:0] KIND_ESCAPE = 3'd4;

    // CSI function codes
    localparam logic [15:0] FN_SGR = 16'd0;
    localparam logic [15:0] FN_CUU = 16'd1;
    localparam logic [15:0] FN_CUD = 16'd2;
    localparam logic [15:0] FN_CUF = 16'd3;
    localparam logic [15:0] FN_CUB = 16'd4;

    // String kinds
    localparam logic [2:0] SK_OSC = 3'd0;
    localparam logic [2:0] SK_DCS = 3'd1;
    localparam logic [2:0] SK_SOS = 3'd2;
    localparam logic [2:0] SK_PM  = 3'd3;
    localparam logic [2:0] SK_APC = 3'd4;

    // Sub-mode codes
    localparam logic [1:0] SUB_IDLE = 2'd0;
    localparam logic [1:0] SUB_BODY = 2'd1;
    localparam logic [1:0] SUB_ESC  = 2'd2;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    // The parameter count field of a command holds parameter counts up to 63.
    localparam int CNT_FIELD_W = 6;
    localparam int FIFO_DEPTH  = 4;

    typedef enum logic [2:0] {
        PM_NORMAL = 3'd0,
        PM_ESCAPE = 3'd1,
        PM_CSI    = 3'd2,
        PM_OSC    = 3'd3,
        PM_DCS    = 3'd4,
        PM_SOS    = 3'd5,
        PM_PM     = 3'd6,
        PM_APC    = 3'd7
    } pm_t;

    typedef enum logic [2:0] {
        OP_CHAR     = 3'd0,
        OP_ESC_PAIR = 3'd1,
        OP_SINGLE   = 3'd2,
        OP_STR_END  = 3'd3,
        OP_CSI      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_SECOND = 2'd1,
        BK_PARAMS = 2'd2
    } bk_state_t;

    typedef struct packed {
        op_t                    op;
        logic [15:0]            data;
        logic [2:0]             skind;
        logic [CNT_FIELD_W-1:0] cnt;
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/tesp_fifo.sv =====
`default_nettype none

module tesp_fifo
    import tesp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tesp_front.sv =====
`default_nettype none

module tesp_front
    import tesp_pkg::*;
#(
    parameter int MAX_PARAMS = 16,
    parameter int CNT_W      = $clog2(MAX_PARAMS + 1),
    parameter int IDX_W      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [7:0]       in_byte,
    output logic                  in_stall,
    input  wire logic             c1_en,
    input  wire logic             q_full,
    input  wire logic             csi_done,
    output logic                  q_push,
    output cmd_t                  q_cmd,
    output logic                  st_we,
    output logic [IDX_W-1:0]      st_addr,
    output logic [15:0]           st_data
);

    pm_t              mode_reg;
    pm_t              mode_next;
    logic [1:0]       sub_reg;
    logic [1:0]       sub_next;
    logic [15:0]      acc_reg;
    logic [15:0]      acc_next;
    logic [23:0]      type_reg;
    logic [23:0]      type_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             pend_reg;
    logic             pend_next;

    logic             accept;
    logic             is_digit;
    logic             in_csi_range;
    logic             is_osc;
    logic [20:0]      acc_wide;
    logic [15:0]      acc_sat;
    logic             room;
    logic             str_end;
    logic             str_acc_upd;
    logic [1:0]       str_sub;
    logic             str_stop;
    logic [CNT_W-1:0] cnt_fin;
    logic             fn_hit;
    logic [15:0]      fn_code;
    logic [2:0]       sk_code;
    logic             pend_set;

    assign in_stall     = q_full || pend_reg;
    assign accept       = in_valid && !in_stall;
    assign is_digit     = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign in_csi_range = (in_byte >= CTRL_LIMIT) && (in_byte < CSI_TOP);
    assign is_osc       = (mode_reg == PM_OSC);
    assign room         = (cnt_reg < CNT_W'(MAX_PARAMS));

    // Decimal accumulate: acc * 10 + digit, saturating at the 16-bit limit.
    assign acc_wide = ({5'b0, acc_reg} << 3) + ({5'b0, acc_reg} << 1)
                    + {13'b0, in_byte - CH_ZERO};
    assign acc_sat  = (|acc_wide[20:16]) ? SAT16 : acc_wide[15:0];

    // Byte classification inside control strings.
    always_comb
    begin
        str_end     = 1'b0;
        str_acc_upd = 1'b0;
        str_sub     = sub_reg;
        str_stop    = 1'b0;
        if (is_osc && sub_reg == SUB_IDLE)
        begin
            if (is_digit)
            begin
                str_acc_upd = 1'b1;
                str_stop    = 1'b1;
            end
            else
            begin
                str_sub = SUB_BODY;
                if (in_byte == CH_SEMI)
                begin
                    str_stop = 1'b1;
                end
            end
        end
        if (!str_stop && str_sub == SUB_ESC)
        begin
            if (in_byte == CH_BSLASH)
            begin
                str_end  = 1'b1;
                str_stop = 1'b1;
            end
            else
            begin
                str_sub = is_osc ? SUB_BODY : SUB_IDLE;
            end
        end
        if (!str_stop)
        begin
            priority if (in_byte == BYTE_ST && c1_en)
            begin
                str_end = 1'b1;
            end
            else if (is_osc && in_byte == BYTE_BEL)
            begin
                str_end = 1'b1;
            end
            else if (in_byte == BYTE_ESC)
            begin
                str_sub = SUB_ESC;
            end
            else
            begin
                str_sub = str_sub;
            end
        end
    end

    // CSI final byte decode; only a final with no intermediates matches.
    always_comb
    begin
        fn_hit  = (type_reg == '0);
        fn_code = FN_SGR;
        priority if (in_byte == CH_SGR)
        begin
            fn_code = FN_SGR;
        end
        else if (in_byte == CH_CUU)
        begin
            fn_code = FN_CUU;
        end
        else if (in_byte == CH_CUD)
        begin
            fn_code = FN_CUD;
        end
        else if (in_byte == CH_CUF)
        begin
            fn_code = FN_CUF;
        end
        else if (in_byte == CH_CUB)
        begin
            fn_code = FN_CUB;
        end
        else
        begin
            fn_hit = 1'b0;
        end
    end

    always_comb
    begin
        unique case (mode_reg)
            PM_OSC:  sk_code = SK_OSC;
            PM_DCS:  sk_code = SK_DCS;
            PM_SOS:  sk_code = SK_SOS;
            PM_PM:   sk_code = SK_PM;
            PM_APC:  sk_code = SK_APC;
            default: sk_code = SK_OSC;
        endcase
    end

    // Next parse mode.
    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            unique case (mode_reg)
                PM_NORMAL:
                begin
                    priority if ((in_byte & LOW7_MASK) >= CTRL_LIMIT)
                    begin
                        mode_next = PM_NORMAL;
                    end
                    else if (in_byte == BYTE_ESC)
                    begin
                        mode_next = PM_ESCAPE;
                    end
                    else if (c1_en && in_byte == BYTE_C1CSI)
                    begin
                        mode_next = PM_CSI;
                    end
                    else if (c1_en && in_byte == BYTE_C1OSC)
                    begin
                        mode_next = PM_OSC;
                    end
                    else if (c1_en && in_byte == BYTE_C1DCS)
                    begin
                        mode_next = PM_DCS;
                    end
                    else if (c1_en && in_byte == BYTE_C1SOS)
                    begin
                        mode_next = PM_SOS;
                    end
                    else if (c1_en && in_byte == BYTE_C1PM)
                    begin
                        mode_next = PM_PM;
                    end
                    else if (c1_en && in_byte == BYTE_C1APC)
                    begin
                        mode_next = PM_APC;
                    end
                    else
                    begin
                        mode_next = PM_NORMAL;
                    end
                end
                PM_ESCAPE:
                begin
                    priority if (in_byte == CH_DCS)
                    begin
                        mode_next = PM_DCS;
                    end
                    else if (in_byte == CH_SOS)
                    begin
                        mode_next = PM_SOS;
                    end
                    else if (in_byte == CH_CSI)
                    begin
                        mode_next = PM_CSI;
                    end
                    else if (in_byte == CH_OSC)
                    begin
                        mode_next = PM_OSC;
                    end
                    else if (in_byte == CH_PM)
                    begin
                        mode_next = PM_PM;
                    end
                    else if (in_byte == CH_APC)
                    begin
                        mode_next = PM_APC;
                    end
                    else
                    begin
                        mode_next = PM_NORMAL;
                    end
                end
                PM_CSI:
                begin
                    mode_next = in_csi_range ? PM_CSI : PM_NORMAL;
                end
                default:
                begin
                    mode_next = str_end ? PM_NORMAL : mode_reg;
                end
            endcase
        end
    end

    // Sequence registers and commands to the back end.
    always_comb
    begin
        sub_next       = sub_reg;
        acc_next       = acc_reg;
        type_next      = type_reg;
        cnt_next       = cnt_reg;
        q_push         = 1'b0;
        q_cmd.op       = OP_CHAR;
        q_cmd.data     = {8'b0, in_byte};
        q_cmd.skind    = SK_OSC;
        q_cmd.cnt      = '0;
        st_we          = 1'b0;
        st_addr        = cnt_reg[IDX_W-1:0];
        st_data        = acc_reg;
        cnt_fin        = cnt_reg;
        pend_set       = 1'b0;
        if (accept)
        begin
            unique case (mode_reg)
                PM_NORMAL:
                begin
                    if ((in_byte & LOW7_MASK) >= CTRL_LIMIT || mode_next == PM_NORMAL)
                    begin
                        q_push = 1'b1;
                    end
                end
                PM_ESCAPE:
                begin
                    if (mode_next == PM_NORMAL)
                    begin
                        q_push = 1'b1;
                        if (in_byte == CH_SAVE || in_byte == CH_RESTORE)
                        begin
                            q_cmd.op   = OP_SINGLE;
                            q_cmd.data = {8'b0, in_byte - CH_ZERO};
                        end
                        else
                        begin
                            q_cmd.op = OP_ESC_PAIR;
                        end
                    end
                end
                PM_CSI:
                begin
                    if (in_csi_range)
                    begin
                        if (is_digit)
                        begin
                            acc_next = acc_sat;
                            sub_next = SUB_BODY;
                        end
                        else if (in_byte == CH_SEMI)
                        begin
                            if (sub_reg != SUB_IDLE)
                            begin
                                st_we    = room;
                                cnt_next = room ? CNT_W'(cnt_reg + 1'b1) : cnt_reg;
                                acc_next = '0;
                                sub_next = SUB_IDLE;
                            end
                        end
                        else
                        begin
                            type_next = {type_reg[15:0], in_byte};
                        end
                    end
                    else
                    begin
                        if (sub_reg != SUB_IDLE)
                        begin
                            st_we   = room;
                            cnt_fin = room ? CNT_W'(cnt_reg + 1'b1) : cnt_reg;
                        end
                        if (fn_hit)
                        begin
                            q_push     = 1'b1;
                            q_cmd.op   = OP_CSI;
                            q_cmd.data = fn_code;
                            q_cmd.cnt  = CNT_FIELD_W'(cnt_fin);
                            pend_set   = (cnt_fin != '0);
                        end
                        sub_next  = SUB_IDLE;
                        acc_next  = '0;
                        type_next = '0;
                        cnt_next  = '0;
                    end
                end
                default:
                begin
                    if (str_end)
                    begin
                        q_push      = 1'b1;
                        q_cmd.op    = OP_STR_END;
                        q_cmd.data  = is_osc ? acc_reg : 16'd0;
                        q_cmd.skind = sk_code;
                        sub_next    = SUB_IDLE;
                        acc_next    = '0;
                        type_next   = '0;
                        cnt_next    = '0;
                    end
                    else
                    begin
                        sub_next = str_sub;
                        if (str_acc_upd)
                        begin
                            acc_next = acc_sat;
                        end
                    end
                end
            endcase
        end
        // The back end reads the stored parameters until its dispatch completes.
        pend_next = pend_set || (pend_reg && !csi_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= PM_NORMAL;
            sub_reg  <= SUB_IDLE;
            acc_reg  <= '0;
            type_reg <= '0;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            sub_reg  <= sub_next;
            acc_reg  <= acc_next;
            type_reg <= type_next;
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tesp_back.sv =====
`default_nettype none

module tesp_back
    import tesp_pkg::*;
#(
    parameter int MAX_PARAMS = 16,
    parameter int IDX_W      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             q_head,
    input  wire logic             q_empty,
    output logic                  q_pop,
    output logic                  csi_done,
    input  wire logic             st_we,
    input  wire logic [IDX_W-1:0] st_addr,
    input  wire logic [15:0]      st_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [2:0]            kind,
    output logic [15:0]           data,
    output logic [2:0]            string_kind,
    output logic                  last
);

    logic [15:0]            store_reg [MAX_PARAMS];
    bk_state_t              state_reg;
    bk_state_t              state_next;
    logic [15:0]            hold_data_reg;
    logic [CNT_FIELD_W-1:0] hold_cnt_reg;
    logic [CNT_FIELD_W-1:0] idx_reg;
    logic [CNT_FIELD_W-1:0] idx_next;

    logic                   out_valid_reg;
    logic [2:0]             kind_reg;
    logic [15:0]            data_reg;
    logic [2:0]             skind_reg;
    logic                   last_reg;

    logic                   out_free;
    logic                   res_valid;
    logic [2:0]             res_kind;
    logic [15:0]            res_data;
    logic [2:0]             res_skind;
    logic                   res_last;
    logic                   param_last;

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign data        = data_reg;
    assign string_kind = skind_reg;
    assign last        = last_reg;

    assign out_free   = !out_valid_reg || !out_stall;
    assign idx_next   = CNT_FIELD_W'(idx_reg + 1'b1);
    assign param_last = (idx_next == hold_cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_pop && q_head.op == OP_ESC_PAIR)
                begin
                    state_next = BK_SECOND;
                end
                else if (q_pop && q_head.op == OP_CSI && q_head.cnt != '0)
                begin
                    state_next = BK_PARAMS;
                end
            end
            BK_SECOND:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_PARAMS:
            begin
                if (out_free && param_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        csi_done  = 1'b0;
        res_valid = 1'b0;
        res_kind  = KIND_CHAR;
        res_data  = q_head.data;
        res_skind = SK_OSC;
        res_last  = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop     = 1'b1;
                    res_valid = 1'b1;
                    unique case (q_head.op)
                        OP_CHAR:
                        begin
                            res_kind = KIND_CHAR;
                        end
                        OP_ESC_PAIR:
                        begin
                            res_kind = KIND_CHAR;
                            res_data = {8'b0, BYTE_ESC};
                            res_last = 1'b0;
                        end
                        OP_SINGLE:
                        begin
                            res_kind = KIND_ESCAPE;
                        end
                        OP_STR_END:
                        begin
                            res_kind  = KIND_STRING;
                            res_skind = q_head.skind;
                        end
                        OP_CSI:
                        begin
                            res_kind = KIND_FUNC;
                            res_last = (q_head.cnt == '0);
                        end
                        default:
                        begin
                            res_kind = KIND_CHAR;
                        end
                    endcase
                end
            end
            BK_SECOND:
            begin
                if (out_free)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_CHAR;
                    res_data  = hold_data_reg;
                end
            end
            BK_PARAMS:
            begin
                if (out_free)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_PARAM;
                    res_data  = store_reg[idx_reg[IDX_W-1:0]];
                    res_last  = param_last;
                    csi_done  = param_last;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_free)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_reg[st_addr] <= st_data;
        end
        if (q_pop)
        begin
            hold_data_reg <= q_head.data;
            hold_cnt_reg  <= q_head.cnt;
            idx_reg       <= '0;
        end
        else if (state_reg == BK_PARAMS && out_free)
        begin
            idx_reg <= idx_next;
        end
        if (out_free && res_valid)
        begin
            kind_reg  <= res_kind;
            data_reg  <= res_data;
            skind_reg <= res_skind;
            last_reg  <= res_last;
        end
    end

endmodule

`default_nettype wire

// ===== sv/terminal_escape_sequence_parser.sv =====
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_stall     in_byte
// output    out_valid / out_stall   kind, data, string_kind, last
// config    cfg_wr_en               cfg_wr_data (c1_enable)
//
// A request is taken every cycle while the command queue has room and no CSI
// dispatch is pending; a byte that yields one result sustains one per cycle
// unless the output stalls, and an ESC pair yields ESC, then its second byte.
// A recognised CSI final yields a function result and one result per stored
// parameter, while the input stalls as the back end reads the store. Reset
// clears all sequence state and the queue; the parameter store is not cleared.

module terminal_escape_sequence_parser
    import tesp_pkg::*;
#(
    parameter int MAX_PARAMS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [15:0]      data,
    output logic [2:0]       string_kind,
    output logic             last
);

    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CNT_W = $clog2(MAX_PARAMS + 1);

    logic             c1_en_reg;
    logic             q_push;
    cmd_t             q_cmd;
    logic             q_pop;
    cmd_t             q_head;
    logic             q_empty;
    logic             q_full;
    logic             csi_done;
    logic             st_we;
    logic [IDX_W-1:0] st_addr;
    logic [15:0]      st_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_en_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            c1_en_reg <= cfg_wr_data;
        end
    end

    tesp_front #(
        .MAX_PARAMS (MAX_PARAMS),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_stall (in_stall),
        .c1_en    (c1_en_reg),
        .q_full   (q_full),
        .csi_done (csi_done),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .st_we    (st_we),
        .st_addr  (st_addr),
        .st_data  (st_data)
    );

    tesp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    tesp_back #(
        .MAX_PARAMS (MAX_PARAMS),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .csi_done    (csi_done),
        .st_we       (st_we),
        .st_addr     (st_addr),
        .st_data     (st_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .data        (data),
        .string_kind (string_kind),
        .last        (last)
    );

endmodule

`default_nettype wire
